@@ sv/sffp_pkg.sv @@
// Shared constants, types and the store request struct of the serial field frame parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sffp_pkg;

  localparam int MAX_FIELDS    = 8;
  localparam int MAX_FIELD_LEN = 16;

  localparam int FIELD_W    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int POS_W      = (MAX_FIELD_LEN > 1) ? $clog2(MAX_FIELD_LEN) : 1;
  localparam int LEN_W      = $clog2(MAX_FIELD_LEN + 1);
  localparam int COUNT_W    = $clog2(MAX_FIELDS + 1);
  localparam int BANK_AW    = FIELD_W + POS_W;
  localparam int ADDR_W     = BANK_AW + 1;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // fixed port widths
  localparam int BYTE_W   = 8;
  localparam int SEL_W    = 3;
  localparam int VALUE_W  = 16;
  localparam int FCOUNT_W = 4;
  localparam int KIND_W   = 3;
  localparam int FLEN_W   = 5;

  localparam logic [BYTE_W-1:0] CH_START = 8'h73; // 's'
  localparam logic [BYTE_W-1:0] CH_END   = 8'h65; // 'e'
  localparam logic [BYTE_W-1:0] CH_SEP   = 8'h2C; // ','
  localparam logic [BYTE_W-1:0] CH_CMD   = 8'h70; // 'p'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31; // '1'
  localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36; // '6'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39; // '9'

  localparam logic [KIND_W-1:0] KIND_CMD = 3'd7;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              clr_en;
    logic              clr_bank;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

`default_nettype wire

@@ sv/sffp_if.sv @@
// Valid/ready channel interfaces for requests into and results out of the parser.
// Depends on sffp_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface sffp_req_if;
  import sffp_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [BYTE_W-1:0]  rx_byte;
  logic [SEL_W-1:0]   field_select;

  modport source (output valid, action, rx_byte, field_select, input ready);
  modport sink   (input valid, action, rx_byte, field_select, output ready);
endinterface

interface sffp_rsp_if;
  import sffp_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  field_value;
  logic                frame_complete;
  logic [FCOUNT_W-1:0] frame_fields;
  logic [KIND_W-1:0]   frame_kind;
  logic [FLEN_W-1:0]   last_field_length;
  logic                receiving;

  modport source (output valid, field_value, frame_complete, frame_fields, frame_kind,
                  last_field_length, receiving, input ready);
  modport sink   (input valid, field_value, frame_complete, frame_fields, frame_kind,
                  last_field_length, receiving, output ready);
endinterface

`default_nettype wire

@@ sv/sffp_store.sv @@
// Two-bank byte store: one bank fills, the other holds the committed frame.
// Per-byte valid bits flag unwritten bytes, which the parser reads as zero. Depends on sffp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sffp_store (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sffp_pkg::store_req_t        ctl,
  output logic [sffp_pkg::BYTE_W-1:0]      rd_data,
  output logic                             rd_valid
);
  import sffp_pkg::*;

  logic [BYTE_W-1:0]     mem [2*BANK_DEPTH];
  logic [BANK_DEPTH-1:0] valid_bits [2];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits[0] <= '0;
      valid_bits[1] <= '0;
      rd_valid      <= 1'b0;
    end else begin
      if (ctl.clr_en) begin
        valid_bits[ctl.clr_bank] <= '0;
      end
      if (ctl.wr_en) begin
        valid_bits[ctl.wr_addr[ADDR_W-1]][ctl.wr_addr[BANK_AW-1:0]] <= 1'b1;
      end
      rd_valid <= valid_bits[ctl.rd_addr[ADDR_W-1]][ctl.rd_addr[BANK_AW-1:0]];
    end
  end

`ifndef SYNTHESIS
  // data bytes and frame end never coincide
  a_no_wr_on_clr: assert property (@(posedge clk) disable iff (rst)
    !(ctl.wr_en && ctl.clr_en))
    else $error("store write and bank clear in the same cycle");

  a_clr_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_en |=> (valid_bits[$past(ctl.clr_bank)] == '0))
    else $error("bank not empty after clear");

  a_wr_marks: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |=>
      valid_bits[$past(ctl.wr_addr[ADDR_W-1])][$past(ctl.wr_addr[BANK_AW-1:0])])
    else $error("written byte not marked valid");
`endif

endmodule

`default_nettype wire

@@ sv/serial_field_frame_parser_unit.sv @@
// Serial field frame parser: byte reception, frame commit and field-to-number queries.
// A received byte passes from idle to the finish state and then into the result register;
//   a query first walks the stored bytes in the conversion state, the stopping non-digit
//   included (at most the field length, 16 here), and then passes through the finish state.
// The unit takes no new request until the last result is loaded; the query loop steps the
//   multiply-by-ten unit once per stored byte, fed by the store's single registered read port.
// Reset (rst, synchronous): the state, frame status, field lengths, result valid and store
//   valid bits clear together; no clearing pass. Depends on sffp_pkg, sffp_if, sffp_store.
`timescale 1ns / 1ps
`default_nettype none

module serial_field_frame_parser_unit (
  input wire logic  clk,
  input wire logic  rst,
  sffp_req_if.sink  req,
  sffp_rsp_if.source rsp
);
  import sffp_pkg::*;

  localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(MAX_FIELDS - 1);
  localparam logic [LEN_W-1:0]   FULL_LEN   = LEN_W'(MAX_FIELD_LEN);

  state_t state, state_next;

  // frame status
  logic               recv;
  logic               end_flag;
  logic               detect;
  logic [FIELD_W-1:0] cur_field;
  logic [LEN_W-1:0]   cur_len;
  logic [COUNT_W-1:0] commit_count;
  logic [LEN_W-1:0]   commit_len;
  logic [KIND_W-1:0]  kind;
  logic               bank;          // bank holding the committed frame
  logic [LEN_W-1:0]   field_len [MAX_FIELDS];

  // query loop
  logic [VALUE_W-1:0] acc;
  logic [POS_W-1:0]   idx;
  logic [FIELD_W-1:0] q_sel;
  logic [LEN_W-1:0]   q_len;

  logic out_valid;

  // decode
  logic               accept;
  logic               is_byte, is_start, is_end, is_sep, is_data;
  logic [BYTE_W-1:0]  c;
  logic [7:0]         sel_wide;
  logic [FIELD_W-1:0] sel_idx;
  logic               sel_miss;
  logic [LEN_W-1:0]   sel_len;
  logic               start_conv;

  // multiply-by-ten-and-add unit of the query loop
  logic [BYTE_W-1:0]  byte_q;
  logic               is_digit;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] mac;
  logic               last_pos;
  logic               out_free;
  logic               load_out;

  store_req_t         sreq;
  logic [BYTE_W-1:0]  rd_data;
  logic               rd_valid;

  assign c        = req.rx_byte;
  assign accept   = req.valid && req.ready;
  assign is_byte  = (req.action == ACT_BYTE);
  assign is_start = (c == CH_START);
  assign is_end   = (c == CH_END);
  assign is_sep   = (c == CH_SEP);
  assign is_data  = !(is_start || is_end || is_sep);

  assign sel_wide = 8'(req.field_select);
  assign sel_idx  = FIELD_W'(req.field_select);
  // out-of-range selects give 0; the count check covers fields never committed
  assign sel_miss = (sel_wide >= 8'(commit_count)) || (sel_wide >= 8'(MAX_FIELDS));
  assign sel_len  = field_len[sel_idx];
  assign start_conv = !is_byte && !sel_miss && (sel_len != '0);

  // bytes never written in the committed frame read as zero, a non-digit
  assign byte_q   = rd_valid ? rd_data : '0;
  assign is_digit = byte_q inside {[CH_ZERO:CH_NINE]};
  assign digit    = 4'(byte_q - CH_ZERO);
  assign mac      = (acc << 3) + (acc << 1) + VALUE_W'(digit);   // wraps at 16 bits
  assign last_pos = ((LEN_W'(idx) + LEN_W'(1)) == q_len);

  assign out_free = !out_valid || rsp.ready;
  assign load_out = (state == ST_FINISH) && out_free;

  always_comb begin
    sreq          = '0;
    sreq.wr_en    = accept && is_byte && is_data && recv && (cur_len != FULL_LEN);
    sreq.wr_addr  = {~bank, cur_field, POS_W'(cur_len)};
    sreq.wr_data  = c;
    // on 'e' the filled bank becomes committed and the old committed bank is emptied
    sreq.clr_en   = accept && is_byte && is_end;
    sreq.clr_bank = bank;
    if (state == ST_CONV) begin
      sreq.rd_addr = {bank, q_sel, idx + POS_W'(1)};
    end else begin
      sreq.rd_addr = {bank, sel_idx, POS_W'(0)};
    end
  end

  sffp_store u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sreq),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = start_conv ? ST_CONV : ST_FINISH;
        end
      end
      ST_CONV: begin
        if (!is_digit || last_pos) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // frame status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      recv         <= 1'b0;
      end_flag     <= 1'b0;
      detect       <= 1'b0;
      cur_field    <= '0;
      cur_len      <= '0;
      commit_count <= '0;
      commit_len   <= '0;
      kind         <= '0;
      bank         <= 1'b0;
      for (int i = 0; i < MAX_FIELDS; i++) begin
        field_len[i] <= '0;
      end
    end else if (accept && is_byte) begin
      if (is_start) begin
        recv      <= 1'b1;
        end_flag  <= 1'b0;
        detect    <= 1'b1;
        cur_len   <= '0;
        cur_field <= '0;
      end else if (is_end) begin
        field_len[cur_field] <= cur_len;
        recv         <= 1'b0;
        end_flag     <= 1'b1;
        commit_len   <= cur_len;
        commit_count <= COUNT_W'(cur_field) + COUNT_W'(1);
        cur_field    <= '0;
        cur_len      <= '0;
        bank         <= ~bank;
      end else if (is_sep) begin
        field_len[cur_field] <= cur_len;
        // past the last field, later fields overwrite it
        if (cur_field != LAST_FIELD) begin
          cur_field <= cur_field + FIELD_W'(1);
        end
        cur_len <= '0;
      end else begin
        if (detect) begin
          if (c inside {[CH_ONE:CH_SIX]}) begin
            kind <= KIND_W'(c - CH_ZERO);
          end else if (c == CH_CMD) begin
            kind <= KIND_CMD;
          end
          detect <= 1'b0;
        end
        if (sreq.wr_en) begin
          cur_len <= cur_len + LEN_W'(1);
        end
      end
    end
  end

  // query loop registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      acc   <= '0;
      idx   <= '0;
      q_sel <= sel_idx;
      q_len <= sel_len;
    end else if (state == ST_CONV) begin
      if (!is_digit) begin
        acc <= VALUE_W'(byte_q);
      end else begin
        acc <= mac;
        idx <= idx + POS_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.field_value       <= acc;
      rsp.frame_complete    <= end_flag;
      rsp.frame_fields      <= FCOUNT_W'(commit_count);
      rsp.frame_kind        <= kind;
      rsp.last_field_length <= FLEN_W'(commit_len);
      rsp.receiving         <= recv;
    end
  end

  assign rsp.valid = out_valid;

`ifndef SYNTHESIS
  a_conv_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> ((q_len != '0) && (LEN_W'(idx) < q_len)))
    else $error("query loop position out of field");

  a_recv_end_excl: assert property (@(posedge clk) disable iff (rst)
    !(recv && end_flag))
    else $error("receiving and frame complete both set");

  a_end_count: assert property (@(posedge clk) disable iff (rst)
    end_flag |-> (commit_count != '0))
    else $error("committed frame with no fields");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    cur_len <= FULL_LEN)
    else $error("field length beyond capacity");
`endif

endmodule

`default_nettype wire
